[src/dlt645_frame_receiver_macros.svh]
// Assertion macros for the DL/T 645 frame receiver.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef DLT645_FRAME_RECEIVER_MACROS_SVH
`define DLT645_FRAME_RECEIVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DLT645RX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlt645 frame receiver check failed");

// The consequent must hold in the cycle after the antecedent.
`define DLT645RX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlt645 frame receiver check failed");

`endif

[src/dlt645rx_pkg.sv]
// Shared types and constants for the DL/T 645 frame receiver.
// No dependencies.
package dlt645rx_pkg;

  localparam int POSITION_BITS_DEF = 16;

  localparam logic [7:0] START_BYTE      = 8'h68;
  localparam logic [7:0] END_BYTE        = 8'h16;
  localparam logic [7:0] HEADER_MORE     = 8'd9;
  localparam logic [7:0] HEADER_CHECK_IX = 8'd7;
  localparam logic [7:0] FRAME_EXTRA     = 8'd12;
  localparam logic [7:0] CHECKSUM_LEFT   = 8'd2;
  localparam logic [7:0] MAX_FRAME_RESET = 8'd100;

  localparam logic [2:0] EV_IDLE     = 3'd0;
  localparam logic [2:0] EV_START    = 3'd1;
  localparam logic [2:0] EV_BYTE     = 3'd2;
  localparam logic [2:0] EV_OK       = 3'd3;
  localparam logic [2:0] EV_HDR_BAD  = 3'd4;
  localparam logic [2:0] EV_TOO_LONG = 3'd5;
  localparam logic [2:0] EV_SUM_BAD  = 3'd6;
  localparam logic [2:0] EV_IGNORED  = 3'd7;

  localparam logic REG_MAX_FRAME = 1'b0;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_in_block;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  frame_byte;
    logic [7:0]  frame_index;
    logic [7:0]  frame_length;
    logic        block_done;
    logic        block_found;
    logic [15:0] drop_count;
  } out_t;

endpackage

[src/dlt645_frame_receiver.sv]
// Top level of the DL/T 645 frame receiver: byte parser, result register, APB register.
// Depends on dlt645rx_pkg and dlt645_frame_receiver_macros.svh.
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid / in_stall  dlt645rx_pkg::in_t
//   out_      output     out_valid / out_stall dlt645rx_pkg::out_t
//   config    input      psel/penable/pready  max_frame_size at byte address 0
//
// One request is taken per clock cycle unless the result is stalled; its result appears
// in the output register on the next cycle; the sustained rate is one byte per cycle.
// The frame state and the result register are the only storage in the byte path.
// A stalled result holds and stalls the input until it is taken.
// Reset is synchronous and active low; max_frame_size returns to 100.
`include "dlt645_frame_receiver_macros.svh"

module dlt645_frame_receiver #(
  parameter int POSITION_BITS = dlt645rx_pkg::POSITION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dlt645rx_pkg::in_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dlt645rx_pkg::out_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_BODY   = 4'b0100,
    PH_IGNORE = 4'b1000
  } phase_t;

  phase_t                   phase_r, phase_nxt;
  logic [7:0]               left_r, left_nxt;
  logic [7:0]               widx_r, widx_nxt;
  logic [7:0]               len_r, len_nxt;
  logic [7:0]               sum_r, sum_nxt;
  logic                     chk_r, chk_nxt;
  logic [POSITION_BITS-1:0] bpos_r, bpos_nxt;
  logic [POSITION_BITS-1:0] hpos_r, hpos_nxt;
  logic                     hseen_r, hseen_nxt;
  logic                     found_r, found_nxt;
  logic [7:0]               max_r;
  logic                     out_valid_r, out_valid_nxt;
  dlt645rx_pkg::out_t       out_r, res;
  logic                     in_acc;
  logic [7:0]               b;
  logic [POSITION_BITS-1:0] drop_pos;
  logic [31:0]              drop_w;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign b         = in_data.rx_byte;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == dlt645rx_pkg::REG_MAX_FRAME) ? {24'd0, max_r} : 32'd0;

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    widx_nxt  = widx_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    chk_nxt   = chk_r;
    bpos_nxt  = bpos_r;
    hpos_nxt  = hpos_r;
    hseen_nxt = hseen_r;
    found_nxt = found_r;
    res       = '0;
    drop_pos  = '0;
    drop_w    = '0;
    res.event_res = dlt645rx_pkg::EV_IDLE;

    unique case (phase_r)
      PH_HUNT: begin
        if (b == dlt645rx_pkg::START_BYTE) begin
          res.event_res = dlt645rx_pkg::EV_START;
          res.frame_byte = b;
          hpos_nxt  = bpos_r;
          hseen_nxt = 1'b1;
          widx_nxt  = 8'd1;
          left_nxt  = dlt645rx_pkg::HEADER_MORE;
          sum_nxt   = b;
          chk_nxt   = 1'b0;
          phase_nxt = PH_HEADER;
        end
      end
      PH_HEADER: begin
        res.event_res   = dlt645rx_pkg::EV_BYTE;
        res.frame_byte  = b;
        res.frame_index = widx_r;
        sum_nxt  = 8'(sum_r + b);
        if (widx_r == dlt645rx_pkg::HEADER_CHECK_IX) begin
          chk_nxt = (b == dlt645rx_pkg::START_BYTE);
        end
        widx_nxt = 8'(widx_r + 8'd1);
        left_nxt = 8'(left_r - 8'd1);
        if (left_r == 8'd1) begin
          hpos_nxt = POSITION_BITS'(hpos_r + 1'b1);
          if (!chk_nxt) begin
            res.event_res = dlt645rx_pkg::EV_HDR_BAD;
            phase_nxt = PH_HUNT;
          end else if (({1'b0, b} + {1'b0, dlt645rx_pkg::FRAME_EXTRA}) > {1'b0, max_r}) begin
            res.event_res = dlt645rx_pkg::EV_TOO_LONG;
            phase_nxt = PH_HUNT;
          end else begin
            len_nxt   = b;
            left_nxt  = 8'(b + dlt645rx_pkg::CHECKSUM_LEFT);
            chk_nxt   = 1'b0;
            phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        res.event_res   = dlt645rx_pkg::EV_BYTE;
        res.frame_byte  = b;
        res.frame_index = widx_r;
        if (left_r == dlt645rx_pkg::CHECKSUM_LEFT) begin
          chk_nxt = (b == sum_r);
        end else if (left_r > dlt645rx_pkg::CHECKSUM_LEFT) begin
          sum_nxt = 8'(sum_r + b);
        end
        widx_nxt = 8'(widx_r + 8'd1);
        if (left_r <= 8'd1) begin
          left_nxt  = 8'd0;
          phase_nxt = PH_HUNT;
          if (b == dlt645rx_pkg::END_BYTE && chk_nxt) begin
            res.event_res    = dlt645rx_pkg::EV_OK;
            res.frame_length = 8'(len_r + dlt645rx_pkg::FRAME_EXTRA);
            found_nxt = 1'b1;
            phase_nxt = PH_IGNORE;
          end else begin
            res.event_res = dlt645rx_pkg::EV_SUM_BAD;
            hpos_nxt = POSITION_BITS'(hpos_r + 1'b1);
          end
        end else begin
          left_nxt = 8'(left_r - 8'd1);
        end
      end
      PH_IGNORE: begin
        res.event_res = dlt645rx_pkg::EV_IGNORED;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase

    if (in_data.last_in_block) begin
      drop_pos = (found_nxt || !hseen_nxt) ? POSITION_BITS'(bpos_r + 1'b1) : hpos_nxt;
      drop_w   = 32'(drop_pos);
      res.block_done  = 1'b1;
      res.block_found = found_nxt;
      res.drop_count  = drop_w[15:0];
      phase_nxt = PH_HUNT;
      left_nxt  = '0;
      widx_nxt  = '0;
      len_nxt   = '0;
      sum_nxt   = '0;
      chk_nxt   = 1'b0;
      bpos_nxt  = '0;
      hpos_nxt  = '0;
      hseen_nxt = 1'b0;
      found_nxt = 1'b0;
    end else begin
      bpos_nxt = POSITION_BITS'(bpos_r + 1'b1);
    end
  end

  always_comb begin
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      left_r      <= '0;
      widx_r      <= '0;
      len_r       <= '0;
      sum_r       <= '0;
      chk_r       <= 1'b0;
      bpos_r      <= '0;
      hpos_r      <= '0;
      hseen_r     <= 1'b0;
      found_r     <= 1'b0;
      max_r       <= dlt645rx_pkg::MAX_FRAME_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r <= phase_nxt;
        left_r  <= left_nxt;
        widx_r  <= widx_nxt;
        len_r   <= len_nxt;
        sum_r   <= sum_nxt;
        chk_r   <= chk_nxt;
        bpos_r  <= bpos_nxt;
        hpos_r  <= hpos_nxt;
        hseen_r <= hseen_nxt;
        found_r <= found_nxt;
      end
      if (psel && penable && pwrite && pready && paddr[2] == dlt645rx_pkg::REG_MAX_FRAME) begin
        max_r <= pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= res;
    end
  end

  `DLT645RX_ASSERT_NEXT(a_block_clears, in_acc && in_data.last_in_block, phase_r == PH_HUNT && bpos_r == '0 && !found_r)
  `DLT645RX_ASSERT_NEXT(a_ignore_holds, in_acc && phase_r == PH_IGNORE && !in_data.last_in_block, phase_r == PH_IGNORE && found_r)
  `DLT645RX_ASSERT_NOW(a_ok_length, out_valid_r && out_r.event_res == dlt645rx_pkg::EV_OK, out_r.frame_length >= dlt645rx_pkg::FRAME_EXTRA && (out_r.block_found || !out_r.block_done))

endmodule

[tb/dlt645_frame_checker.sv]
`timescale 1ns / 1ps
// Watches the request, result and register ports of the DL/T 645 frame receiver,
// predicts one result per accepted request and compares it field by field.
// Depends on dlt645rx_pkg.
module dlt645_frame_checker
  import dlt645rx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          outstanding
);

  typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_BODY, PH_IGNORE} rx_phase_e;

  logic [7:0]  max_size;
  rx_phase_e   phase;
  logic [7:0]  left;
  logic [7:0]  wr_ix;
  logic [7:0]  len_field;
  logic [7:0]  sum;
  logic        match;
  logic [15:0] blk_pos;
  logic [15:0] head_pos;
  logic        head_seen;
  logic        found;

  out_t expected_events[$];
  out_t exp_res;

  function automatic void clear_block();
    phase     = PH_HUNT;
    left      = '0;
    wr_ix     = '0;
    len_field = '0;
    sum       = '0;
    match     = 1'b0;
    blk_pos   = '0;
    head_pos  = '0;
    head_seen = 1'b0;
    found     = 1'b0;
  endfunction

  function automatic out_t predict_frame_event(in_t req);
    out_t       r;
    logic [7:0] b;
    b = req.rx_byte;
    r = '0;
    r.event_res = EV_IDLE;
    case (phase)
      PH_HUNT: begin
        if (b == START_BYTE) begin
          r.event_res   = EV_START;
          r.frame_byte  = b;
          r.frame_index = '0;
          head_pos  = blk_pos;
          head_seen = 1'b1;
          wr_ix     = 8'd1;
          left      = HEADER_MORE;
          sum       = b;
          match     = 1'b0;
          phase     = PH_HEADER;
        end
      end
      PH_HEADER: begin
        r.event_res   = EV_BYTE;
        r.frame_byte  = b;
        r.frame_index = wr_ix;
        sum = sum + b;
        if (wr_ix == HEADER_CHECK_IX) match = (b == START_BYTE);
        wr_ix = wr_ix + 8'd1;
        left  = left - 8'd1;
        if (left == 8'd0) begin
          head_pos = head_pos + 16'd1;
          if (!match) begin
            r.event_res = EV_HDR_BAD;
            phase = PH_HUNT;
          end else if (int'(b) + int'(FRAME_EXTRA) > int'(max_size)) begin
            r.event_res = EV_TOO_LONG;
            phase = PH_HUNT;
          end else begin
            len_field = b;
            left      = b + 8'd2;
            match     = 1'b0;
            phase     = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        r.event_res   = EV_BYTE;
        r.frame_byte  = b;
        r.frame_index = wr_ix;
        if (left == CHECKSUM_LEFT) match = (b == sum);
        else if (left > CHECKSUM_LEFT) sum = sum + b;
        wr_ix = wr_ix + 8'd1;
        if (left <= 8'd1) begin
          left  = '0;
          phase = PH_HUNT;
          if (b == END_BYTE && match) begin
            r.event_res    = EV_OK;
            r.frame_length = len_field + FRAME_EXTRA;
            found = 1'b1;
            phase = PH_IGNORE;
          end else begin
            r.event_res = EV_SUM_BAD;
            head_pos = head_pos + 16'd1;
          end
        end else begin
          left = left - 8'd1;
        end
      end
      default: r.event_res = EV_IGNORED;
    endcase
    if (req.last_in_block) begin
      r.block_done  = 1'b1;
      r.block_found = found;
      r.drop_count  = (found || !head_seen) ? blk_pos + 16'd1 : head_pos;
      clear_block();
    end else begin
      blk_pos = blk_pos + 16'd1;
    end
    return r;
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      max_size = MAX_FRAME_RESET;
      clear_block();
      expected_events.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_MAX_FRAME, 2'b00})
        max_size = pwdata[7:0];
      if (in_valid && !in_stall) expected_events.push_back(predict_frame_event(in_data));
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $error("result with no request pending: event_res %0d", out_data.event_res);
          mismatches++;
        end else begin
          exp_res = expected_events.pop_front();
          check_field("event_res", exp_res.event_res, out_data.event_res);
          check_field("frame_byte", exp_res.frame_byte, out_data.frame_byte);
          check_field("frame_index", exp_res.frame_index, out_data.frame_index);
          check_field("frame_length", exp_res.frame_length, out_data.frame_length);
          check_field("block_done", exp_res.block_done, out_data.block_done);
          check_field("block_found", exp_res.block_found, out_data.block_found);
          check_field("drop_count", exp_res.drop_count, out_data.drop_count);
        end
      end
    end
    outstanding <= expected_events.size();
  end

endmodule

[tb/tb_dlt645_frame_receiver.sv]
`timescale 1ns / 1ps
// Top of the DL/T 645 frame receiver testbench: clock, reset, byte blocks, register
// writes and result stalls. Depends on dlt645rx_pkg, the receiver and the checker.
module tb_dlt645_frame_receiver;
  import dlt645rx_pkg::*;

  localparam int CYCLE_LIMIT     = 800000;
  localparam int MAX_WAIT        = 12;
  localparam int REQUESTS_TARGET = 750;
  localparam int HOLD_AFTER      = 300;
  localparam int HOLD_CYCLES     = 200;

  typedef enum {FLAW_NONE, FLAW_HEADER, FLAW_SUM, FLAW_END, FLAW_CUT} frame_flaw_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          outstanding;
  int          cycles;
  int          sent_count;
  int          send_burst;
  int          take_burst;
  logic [7:0]  frame_limit;
  logic [7:0]  block_q[$];
  logic [7:0]  phase_limits[$];

  dlt645_frame_receiver dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  dlt645_frame_checker frame_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int draw_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [7:0] byte_other_than(logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom); while (b == avoid);
    return b;
  endfunction

  task automatic send_req(logic [7:0] b, logic last);
    int gap;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{rx_byte: b, last_in_block: last};
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic send_block();
    foreach (block_q[i]) send_req(block_q[i], i == block_q.size() - 1);
    block_q.delete();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_max_frame(logic [7:0] v);
    wait_idle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_MAX_FRAME, 2'b00};
    pwdata  <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    frame_limit = v;
  endtask

  task automatic add_noise(int n);
    repeat (n) block_q.push_back(byte_other_than(START_BYTE));
  endtask

  task automatic add_random(int n);
    repeat (n) block_q.push_back(8'($urandom));
  endtask

  task automatic add_frame(int len, frame_flaw_e flaw);
    logic [7:0] f[$];
    logic [7:0] sum;
    int         cut;
    f.push_back(START_BYTE);
    repeat (6) f.push_back(8'($urandom));
    f.push_back(flaw == FLAW_HEADER ? byte_other_than(START_BYTE) : START_BYTE);
    f.push_back(8'($urandom));
    f.push_back(len[7:0]);
    repeat (len) f.push_back(8'($urandom));
    sum = '0;
    foreach (f[i]) sum += f[i];
    f.push_back(flaw == FLAW_SUM ? byte_other_than(sum) : sum);
    f.push_back(flaw == FLAW_END ? byte_other_than(END_BYTE) : END_BYTE);
    cut = (flaw == FLAW_CUT) ? $urandom_range(1, f.size() - 1) : f.size();
    for (int i = 0; i < cut; i++) block_q.push_back(f[i]);
  endtask

  task automatic random_block();
    int room;
    int pick;
    int len;
    int kind;
    room = int'(frame_limit) - int'(FRAME_EXTRA);
    pick = $urandom_range(0, 39);
    if (pick == 0) len = $urandom_range(0, 255);
    else if (pick == 1 && room >= 0) len = room;
    else if (pick == 2 && room < 255) len = (room < 0) ? 0 : room + 1;
    else len = $urandom_range(0, (room >= 0 && room < 8) ? room : 8);
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      add_noise($urandom_range(0, 3));
      add_frame(len, FLAW_NONE);
      add_random($urandom_range(0, 3));
    end else if (kind < 75) begin
      add_noise($urandom_range(0, 2));
      add_frame(len, frame_flaw_e'($urandom_range(1, 3)));
      if ($urandom_range(0, 1) == 1) add_frame($urandom_range(0, 4), FLAW_NONE);
    end else if (kind < 85) begin
      add_noise($urandom_range(0, 2));
      add_frame(len, FLAW_CUT);
    end else if (kind < 95) begin
      add_noise($urandom_range(1, 8));
    end else begin
      add_random($urandom_range(1, 12));
    end
    send_block();
    if ($urandom_range(0, 19) == 0) wait_idle();
  endtask

  initial begin
    int phase_end;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    frame_limit = MAX_FRAME_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed blocks at the reset frame size.
    block_q.push_back(START_BYTE);
    send_block();
    add_frame(0, FLAW_NONE);
    send_block();
    block_q.push_back(8'hFF);
    block_q.push_back(8'h00);
    add_frame(1, FLAW_HEADER);
    send_block();
    add_frame(89, FLAW_NONE);
    while (block_q.size() > 12) block_q.pop_back();
    send_block();
    add_frame(2, FLAW_SUM);
    add_frame(1, FLAW_END);
    add_frame(0, FLAW_NONE);
    block_q.push_back(START_BYTE);
    block_q.push_back(START_BYTE);
    send_block();
    add_noise(2);
    add_frame(3, FLAW_CUT);
    send_block();

    phase_limits = '{8'd255, 8'd12, 8'($urandom_range(13, 254)), 8'd0, 8'd11,
                     MAX_FRAME_RESET, 8'($urandom_range(12, 40))};
    foreach (phase_limits[p]) begin
      write_max_frame(phase_limits[p]);
      phase_end = sent_count + REQUESTS_TARGET / phase_limits.size();
      while (sent_count < phase_end) random_block();
    end

    wait_idle();
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    int taken;
    int hold;
    taken = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      // One long hold-off lets the receiver fill up and stall incoming requests.
      if (taken == HOLD_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      hold = draw_wait(take_burst);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

endmodule
